>>> design/pstt_pkg.sv
// Shared types and constants for the priority sorted task table.
`default_nettype none
package pstt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SCAN   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_INVALID   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t          op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } chain_cmd_t;

  // where a cell sits relative to the fill level
  typedef struct packed {
    logic occ;     // holds a live entry
    logic at_end;  // first free slot
    logic tail;    // last live entry
  } cell_pos_t;

endpackage
`default_nettype wire

>>> design/priority_sorted_task_table_unit.sv
// Top level of the priority sorted task table: control, fill count and result register.
//
// Input channel (in_valid/in_ready) carries opcode, task_id, task_priority.
// Output channel (out_valid/out_ready) carries status, entry_id,
// entry_priority, entry_count and last.
// Insert, remove and no-op: the transaction is accepted, the
// cell row shifts at that edge, and the single result sits in the output
// register the next cycle. in_ready is high again as soon as that result
// is taken or in the same cycle it is taken.
// Scan of N entries gives N results, one per cycle while out_ready holds:
// the row rotates by one cell per result and is back in place after the
// last one; no new transaction is accepted until then.
// A remove looks for the first matching id by a found flag that ripples
// combinationally through all cells, which sets the clock period.
// When the receiver stalls the output register holds its result and the
// scan waits; nothing is dropped.
// Reset (rst, synchronous) empties the table and the output register; slot
// contents are not cleared.
`default_nettype none
module priority_sorted_task_table_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [1:0]                    opcode,
  input  wire [pstt_pkg::ID_W-1:0]     task_id,
  input  wire [pstt_pkg::PRIO_W-1:0]   task_priority,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [2:0]                   status,
  output logic [pstt_pkg::ID_W-1:0]    entry_id,
  output logic [pstt_pkg::PRIO_W-1:0]  entry_priority,
  output logic [pstt_pkg::CNT_W-1:0]   entry_count,
  output logic                         last
);
  import pstt_pkg::*;

  fsm_state_t        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  idx, idx_next;
  chain_cmd_t        cmd;
  logic [ID_W-1:0]   head_id;
  logic [PRIO_W-1:0] head_prio;
  logic              found;
  logic              out_free;
  logic              accept;
  logic              load;
  status_t           ld_status;
  logic [ID_W-1:0]   ld_id;
  logic [PRIO_W-1:0] ld_prio;
  logic              ld_last;
  logic              scan_end;

  pstt_chain u_chain (
    .clk       (clk),
    .cmd       (cmd),
    .count     (count),
    .head_id   (head_id),
    .head_prio (head_prio),
    .found     (found)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == FSM_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign scan_end = {1'b0, idx} == CNT_W'(count - 1'b1);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    cmd.op     = CELL_HOLD;
    cmd.id     = task_id;
    cmd.prio   = task_priority;
    load       = 1'b0;
    ld_status  = ST_OK;
    ld_id      = '0;
    ld_prio    = '0;
    ld_last    = 1'b1;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (opcode_t'(opcode))
            OP_INSERT: begin
              if (task_id == '0) begin
                ld_status = ST_INVALID;
              end else if (count == CNT_W'(TABLE_DEPTH)) begin
                ld_status = ST_FULL;
              end else begin
                cmd.op     = CELL_INSERT;
                count_next = count + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (task_id == '0) begin
                ld_status = ST_INVALID;
              end else if (count == '0) begin
                ld_status = ST_EMPTY;
              end else begin
                // cells only shift when some cell matched
                cmd.op = CELL_REMOVE;
                if (found) begin
                  count_next = count - 1'b1;
                end else begin
                  ld_status = ST_NOT_FOUND;
                end
              end
            end
            OP_SCAN: begin
              if (count == '0) begin
                ld_status = ST_EMPTY;
              end else begin
                load       = 1'b0;
                idx_next   = '0;
                state_next = FSM_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_SCAN: begin
        if (out_free) begin
          load     = 1'b1;
          cmd.op   = CELL_ROTATE;
          ld_id    = head_id;
          ld_prio  = head_prio;
          ld_last  = scan_end;
          idx_next = idx + 1'b1;
          if (scan_end) begin
            state_next = FSM_IDLE;
          end
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status         <= ld_status;
      entry_id       <= ld_id;
      entry_priority <= ld_prio;
      entry_count    <= count_next;
      last           <= ld_last;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count above table depth");

  a_scan_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_SCAN) |=> (count == $past(count)))
    else $error("fill count changed during scan");

  a_scan_step_loads: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_SCAN && out_free) |=> out_valid)
    else $error("scan step without result");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_INSERT && task_id != '0 && count != CNT_W'(TABLE_DEPTH))
    |=> (count == CNT_W'($past(count) + 1'b1)))
    else $error("insert did not grow table");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_SCAN) |-> (count != '0))
    else $error("scan running on empty table");
`endif

endmodule
`default_nettype wire

>>> design/pstt_cell.sv
// One slot of the sorted table: holds an id and priority, shifts with its neighbors.
`default_nettype none
module pstt_cell (
  input  wire                          clk,
  input  wire pstt_pkg::chain_cmd_t    cmd,
  input  wire pstt_pkg::cell_pos_t     pos,
  input  wire                          gt_in,
  input  wire                          found_in,
  input  wire [pstt_pkg::ID_W-1:0]     left_id,
  input  wire [pstt_pkg::PRIO_W-1:0]   left_prio,
  input  wire [pstt_pkg::ID_W-1:0]     right_id,
  input  wire [pstt_pkg::PRIO_W-1:0]   right_prio,
  input  wire [pstt_pkg::ID_W-1:0]     head_id,
  input  wire [pstt_pkg::PRIO_W-1:0]   head_prio,
  output logic                         gt_out,
  output logic                         found_out,
  output logic [pstt_pkg::ID_W-1:0]    id,
  output logic [pstt_pkg::PRIO_W-1:0]  prio
);
  import pstt_pkg::*;

  logic [ID_W-1:0]   id_next;
  logic [PRIO_W-1:0] prio_next;

  always_comb begin
    gt_out    = pos.occ && (prio > cmd.prio);
    found_out = found_in || (pos.occ && (id == cmd.id));
    id_next   = id;
    prio_next = prio;
    case (cmd.op)
      CELL_INSERT: begin
        if (gt_in) begin
          id_next   = left_id;
          prio_next = left_prio;
        end else if (gt_out || pos.at_end) begin
          id_next   = cmd.id;
          prio_next = cmd.prio;
        end
      end
      CELL_REMOVE: begin
        // everything from the first match onward closes the gap
        if (found_out) begin
          id_next   = right_id;
          prio_next = right_prio;
        end
      end
      CELL_ROTATE: begin
        if (pos.tail) begin
          id_next   = head_id;
          prio_next = head_prio;
        end else if (pos.occ) begin
          id_next   = right_id;
          prio_next = right_prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id   <= id_next;
    prio <= prio_next;
  end

endmodule
`default_nettype wire

>>> design/pstt_chain.sv
// Row of table cells with neighbor links and fill-level decode.
`default_nettype none
module pstt_chain (
  input  wire                          clk,
  input  wire pstt_pkg::chain_cmd_t    cmd,
  input  wire [pstt_pkg::CNT_W-1:0]    count,
  output logic [pstt_pkg::ID_W-1:0]    head_id,
  output logic [pstt_pkg::PRIO_W-1:0]  head_prio,
  output logic                         found
);
  import pstt_pkg::*;

  logic              gt    [TABLE_DEPTH];
  logic              fnd   [TABLE_DEPTH];
  logic [ID_W-1:0]   ids   [TABLE_DEPTH];
  logic [PRIO_W-1:0] prios [TABLE_DEPTH];
  cell_pos_t         pos   [TABLE_DEPTH];

  genvar i;
  generate
    for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic              gt_l;
      logic              fnd_l;
      logic [ID_W-1:0]   id_l;
      logic [PRIO_W-1:0] prio_l;
      logic [ID_W-1:0]   id_r;
      logic [PRIO_W-1:0] prio_r;

      assign pos[i].occ    = CNT_W'(i) < count;
      assign pos[i].at_end = count == CNT_W'(i);
      assign pos[i].tail   = count == CNT_W'(i + 1);

      if (i == 0) begin : g_first
        assign gt_l   = 1'b0;
        assign fnd_l  = 1'b0;
        assign id_l   = '0;
        assign prio_l = '0;
      end else begin : g_mid
        assign gt_l   = gt[i-1];
        assign fnd_l  = fnd[i-1];
        assign id_l   = ids[i-1];
        assign prio_l = prios[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
        assign id_r   = ids[i];
        assign prio_r = prios[i];
      end else begin : g_inner
        assign id_r   = ids[i+1];
        assign prio_r = prios[i+1];
      end

      pstt_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .pos        (pos[i]),
        .gt_in      (gt_l),
        .found_in   (fnd_l),
        .left_id    (id_l),
        .left_prio  (prio_l),
        .right_id   (id_r),
        .right_prio (prio_r),
        .head_id    (ids[0]),
        .head_prio  (prios[0]),
        .gt_out     (gt[i]),
        .found_out  (fnd[i]),
        .id         (ids[i]),
        .prio       (prios[i])
      );
    end
  endgenerate

  assign head_id   = ids[0];
  assign head_prio = prios[0];
  assign found     = fnd[TABLE_DEPTH-1];

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the priority sorted task table: random handshakes, in-order result predictor.
`timescale 1ns / 100ps
module testbench;
  import pstt_pkg::*;

  typedef struct {
    opcode_t          op;
    logic [ID_W-1:0]  id;
    logic [PRIO_W-1:0] prio;
    int               gap;
  } table_req_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [CNT_W-1:0]   count;
    logic               last;
  } table_result_t;

  localparam int NUM_RANDOM   = 320;
  localparam int IDLE_LIMIT   = 1000;
  localparam int LONG_HOLD    = 150;
  localparam int DRAIN_CYCLES = 20;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  wire                 in_ready;
  logic [1:0]          opcode = OP_NOP;
  logic [ID_W-1:0]     task_id = '0;
  logic [PRIO_W-1:0]   task_priority = '0;
  wire                 out_valid;
  logic                out_ready = 1'b0;
  wire [2:0]           status;
  wire [ID_W-1:0]      entry_id;
  wire [PRIO_W-1:0]    entry_priority;
  wire [CNT_W-1:0]     entry_count;
  wire                 last;

  priority_sorted_task_table_unit uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .task_id        (task_id),
    .task_priority  (task_priority),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .entry_id       (entry_id),
    .entry_priority (entry_priority),
    .entry_count    (entry_count),
    .last           (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the task table
  logic [ID_W-1:0]   held_ids [TABLE_DEPTH];
  logic [PRIO_W-1:0] held_prios [TABLE_DEPTH];
  int                held_count = 0;

  table_req_t    pending_reqs [$];
  table_result_t due_results [$];

  int  errors = 0;
  int  reqs_queued = 0;
  int  results_seen = 0;
  int  n_ops = 0;
  int  n_scans = 0;
  int  n_full = 0;
  int  n_not_found = 0;
  int  n_invalid = 0;
  int  peak_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  function automatic void push_result(status_t st, logic [ID_W-1:0] id,
                                      logic [PRIO_W-1:0] prio, logic lst);
    table_result_t r;
    r.status = st;
    r.id     = id;
    r.prio   = prio;
    r.count  = held_count[CNT_W-1:0];
    r.last   = lst;
    due_results.push_back(r);
  endfunction

  // applies one accepted transaction to the shadow table and queues its results
  function automatic void apply_table_op(opcode_t op, logic [ID_W-1:0] id,
                                         logic [PRIO_W-1:0] prio);
    status_t st;
    int      pos;
    int      j;
    n_ops++;
    case (op)
      OP_INSERT: begin
        if (id == '0) begin
          st = ST_INVALID;
        end else if (held_count >= TABLE_DEPTH) begin
          st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_prios[pos] <= prio) pos++;
          for (j = held_count; j > pos; j--) begin
            held_ids[j]   = held_ids[j-1];
            held_prios[j] = held_prios[j-1];
          end
          held_ids[pos]   = id;
          held_prios[pos] = prio;
          held_count++;
          st = ST_OK;
        end
        push_result(st, '0, '0, 1'b1);
      end
      OP_REMOVE: begin
        if (id == '0) begin
          st = ST_INVALID;
        end else if (held_count == 0) begin
          st = ST_EMPTY;
        end else begin
          st = ST_NOT_FOUND;
          pos = 0;
          while (pos < held_count && held_ids[pos] != id) pos++;
          if (pos < held_count) begin
            for (j = pos; j + 1 < held_count; j++) begin
              held_ids[j]   = held_ids[j+1];
              held_prios[j] = held_prios[j+1];
            end
            held_count--;
            st = ST_OK;
          end
        end
        push_result(st, '0, '0, 1'b1);
      end
      OP_SCAN: begin
        n_scans++;
        st = (held_count == 0) ? ST_EMPTY : ST_OK;
        if (held_count == 0) push_result(ST_EMPTY, '0, '0, 1'b1);
        for (j = 0; j < held_count; j++)
          push_result(ST_OK, held_ids[j], held_prios[j], j + 1 == held_count);
      end
      default: begin
        st = ST_OK;
        push_result(ST_OK, '0, '0, 1'b1);
      end
    endcase
    if (st == ST_FULL) n_full++;
    if (st == ST_NOT_FOUND) n_not_found++;
    if (st == ST_INVALID) n_invalid++;
    if (held_count > peak_count) peak_count = held_count;
  endfunction

  // every third band of 40 items goes back to back
  function automatic void add_req(opcode_t op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
    table_req_t q;
    q.op   = op;
    q.id   = id;
    q.prio = prio;
    q.gap  = ((reqs_queued / 40) % 3 == 2) ? 0 : $urandom_range(0, 12);
    pending_reqs.push_back(q);
    reqs_queued++;
  endfunction

  // mostly a small pool so removes hit held ids; sometimes the null id or any id
  function automatic logic [ID_W-1:0] draw_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 85) return ID_W'($urandom_range(1, 24));
    return ID_W'($urandom_range(0, 255));
  endfunction

  // narrow priorities give many ties
  function automatic logic [PRIO_W-1:0] draw_prio();
    if ($urandom_range(0, 1) == 0) return PRIO_W'($urandom_range(0, 7));
    return PRIO_W'($urandom_range(0, 255));
  endfunction

  // sender: holds each transaction until accepted, gap before each one
  always @(negedge clk) begin : sender
    table_req_t q;
    int g;
    g = gap_left;
    if (in_taken && pending_reqs.size() > 0) g = pending_reqs[0].gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (g > 0) begin
        in_valid <= 1'b0;
        gap_left <= g - 1;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        in_valid      <= 1'b1;
        opcode        <= q.op;
        task_id       <= q.id;
        task_priority <= q.prio;
        gap_left      <= 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall per result, calm bands, two long hold-offs
  always @(negedge clk) begin : receiver
    int s;
    s = stall_left;
    if (out_taken) begin
      s = (results_seen % 120 >= 40 && results_seen % 120 < 80) ? 0 : $urandom_range(0, 12);
      if (results_seen == 60 || results_seen == 300) s = LONG_HOLD;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready  <= (s == 0);
      stall_left <= (s > 0) ? s - 1 : 0;
    end
  end

  always @(posedge clk) begin : monitor
    table_result_t exp;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      // check before predicting: a result never leaves in the cycle its transaction enters
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d id %0d prio %0d count %0d last %0d",
                 status, entry_id, entry_priority, entry_count, last);
          errors++;
        end else begin
          exp = due_results.pop_front();
          if (status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, status);
            errors++;
          end
          if (entry_id !== exp.id) begin
            $error("entry_id: expected %0d, got %0d", exp.id, entry_id);
            errors++;
          end
          if (entry_priority !== exp.prio) begin
            $error("entry_priority: expected %0d, got %0d", exp.prio, entry_priority);
            errors++;
          end
          if (entry_count !== exp.count) begin
            $error("entry_count: expected %0d, got %0d", exp.count, entry_count);
            errors++;
          end
          if (last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        apply_table_op(opcode_t'(opcode), task_id, task_priority);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a transaction", IDLE_LIMIT);
        $display("FAIL priority_sorted_task_table_unit");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int mode;
    int len;
    int k;
    int r;
    // directed: empty table, null ids, extremes, ties, duplicates, misses
    add_req(OP_SCAN,   8'h00, 8'h00);
    add_req(OP_REMOVE, 8'h05, 8'h00);
    add_req(OP_REMOVE, 8'h00, 8'hff);
    add_req(OP_INSERT, 8'h00, 8'h7f);
    add_req(OP_NOP,    8'hff, 8'hff);
    add_req(OP_INSERT, 8'hff, 8'hff);
    add_req(OP_INSERT, 8'h01, 8'h00);
    add_req(OP_INSERT, 8'h80, 8'h80);
    add_req(OP_INSERT, 8'h01, 8'h80);
    add_req(OP_INSERT, 8'h7f, 8'h00);
    add_req(OP_SCAN,   8'hff, 8'hff);
    add_req(OP_REMOVE, 8'h55, 8'h00);
    add_req(OP_REMOVE, 8'h01, 8'h00);
    add_req(OP_REMOVE, 8'hff, 8'h00);
    add_req(OP_SCAN,   8'h00, 8'h00);
    add_req(OP_NOP,    8'h00, 8'h00);
    add_req(OP_REMOVE, 8'h00, 8'h00);
    add_req(OP_INSERT, 8'haa, 8'h55);
    add_req(OP_INSERT, 8'h55, 8'haa);
    add_req(OP_SCAN,   8'h00, 8'h00);

    // random bursts: fill toward full, drain toward empty, or mixed
    k = reqs_queued + NUM_RANDOM;
    while (reqs_queued < k) begin
      mode = $urandom_range(0, 2);
      len  = (mode == 0) ? 24 : (mode == 1) ? 30 : 20;
      repeat (len) begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       r = (r < 88) ? 0 : (r < 95) ? 2 : (r < 98) ? 1 : 3;
          1:       r = (r < 80) ? 1 : (r < 90) ? 2 : (r < 96) ? 0 : 3;
          default: r = (r < 40) ? 0 : (r < 75) ? 1 : (r < 92) ? 2 : 3;
        endcase
        add_req(opcode_t'(r), draw_id(), draw_prio());
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      errors++;
    end

    $display("Ran %0d table operations (%0d scans), %0d results checked, peak fill %0d of %0d",
             n_ops, n_scans, results_seen, peak_count, TABLE_DEPTH);
    $display("Rejects seen: %0d full, %0d not found, %0d null id; %0d errors",
             n_full, n_not_found, n_invalid, errors);
    if (errors == 0) begin
      $display("PASS priority_sorted_task_table_unit");
    end else begin
      $display("FAIL priority_sorted_task_table_unit");
    end
    $finish;
  end

endmodule
